### rtl/core/swec_pkg.sv
// Shared types and constants of the sliding window event counter.
`default_nettype none

package swec_pkg;

  localparam int unsigned NUM_BUCKETS = 5;
  localparam int unsigned IDX_W       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned CNT_W       = $clog2(NUM_BUCKETS + 1);
  localparam int unsigned NIBBLES     = 8;
  localparam int unsigned FOLD_W      = $clog2(NIBBLES * 15 * (NUM_BUCKETS - 1) + 1);
  localparam int unsigned MOD_STEPS   = FOLD_W - IDX_W + 1;
  localparam int unsigned MSTEP_W     = $clog2(MOD_STEPS);

  // residue of 16**i mod NUM_BUCKETS for each nibble of the minute
  localparam logic [NIBBLES-1:0][IDX_W-1:0] NIB_WT = {
    IDX_W'((1 << 28) % NUM_BUCKETS),
    IDX_W'((1 << 24) % NUM_BUCKETS),
    IDX_W'((1 << 20) % NUM_BUCKETS),
    IDX_W'((1 << 16) % NUM_BUCKETS),
    IDX_W'((1 << 12) % NUM_BUCKETS),
    IDX_W'((1 << 8) % NUM_BUCKETS),
    IDX_W'((1 << 4) % NUM_BUCKETS),
    IDX_W'(1 % NUM_BUCKETS)
  };

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    CMD_RECORD  = 2'd0,
    CMD_QUERY   = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_MOD,
    S_WRITE,
    S_READ,
    S_ADD,
    S_SUM,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] stamp;
  } bucket_t;

  typedef struct packed {
    logic    clr;
    logic    wr_en;
    logic    rd_en;
    idx_t    addr;
    bucket_t wr_data;
  } store_req_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
  } mod_req_t;

  typedef struct packed {
    logic done;
    idx_t rem;
  } mod_rsp_t;

endpackage

`default_nettype wire

### rtl/core/swec_if.sv
// Handshake interfaces for input items and result items.
`default_nettype none

interface swec_in_if import swec_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] minute;
  logic [31:0] delta;

  modport source (output valid, cmd, minute, delta, input ready);
  modport sink   (input valid, cmd, minute, delta, output ready);
endinterface

interface swec_out_if import swec_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [34:0] recent_total;
  logic [47:0] lifetime_count;
  logic        window_advanced;

  modport source (output valid, recent_total, lifetime_count, window_advanced, input ready);
  modport sink   (input valid, recent_total, lifetime_count, window_advanced, output ready);
endinterface

`default_nettype wire

### rtl/core/swec_mod_unit.sv
// Minute modulo bucket count: nibble fold by residue weights, then one trim step per cycle.
`default_nettype none

module swec_mod_unit import swec_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  localparam logic [FOLD_W-1:0] MOD_BASE = FOLD_W'(NUM_BUCKETS);

  logic               busy;
  logic               done;
  logic [FOLD_W-1:0]  part;
  logic [MSTEP_W-1:0] step;
  logic [FOLD_W-1:0]  fold;
  logic [FOLD_W-1:0]  nib_ext;
  logic [FOLD_W-1:0]  wt_ext;
  logic [FOLD_W-1:0]  sub_val;

  always_comb begin
    fold    = '0;
    nib_ext = '0;
    wt_ext  = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      nib_ext = FOLD_W'(req.dividend[4*i +: 4]);
      wt_ext  = FOLD_W'(NIB_WT[i]);
      fold    = fold + nib_ext * wt_ext;
    end
    sub_val = MOD_BASE << step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        part <= fold;
        step <= MSTEP_W'(MOD_STEPS - 1);
      end else if (busy) begin
        if (part >= sub_val) begin
          part <= part - sub_val;
        end
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = part[IDX_W-1:0];

endmodule

`default_nettype wire

### rtl/core/swec_bucket_store.sv
// Bucket memory with per-entry valid bits and a registered read port.
`default_nettype none

module swec_bucket_store import swec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  store_req_t req,
  output bucket_t    rd_data
);

  bucket_t                mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] valid;
  bucket_t                rd_word;
  logic                   rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= valid[req.addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_word : '0;

endmodule

`default_nettype wire

### rtl/core/sliding_window_event_counter_top.sv
// Sliding window event counter: sequencer, counters and result register.
// Each item is taken alone and yields one result. A query, a clear, or an
// advance to the current minute goes from S_MOVE through the bucket sweep to
// S_DONE; result valid rises in the same cycle as the block returns to
// S_IDLE for the next item. A record to the current minute adds S_READ and
// S_ADD to read and write back the active bucket; a move that steps the ring
// forward adds S_WRITE; a move that recomputes the bucket index as minute mod
// NUM_BUCKETS adds S_MOD and S_WRITE, as the modulo unit folds the minute and
// then trims it with one compare and subtract per cycle. The recent sum is
// formed by a sweep of the bucket memory, one bucket read per cycle. The
// result waits in an output register, so the next item is accepted while it
// is still pending; a result left waiting holds the following item in S_DONE.
`default_nettype none

module sliding_window_event_counter_top import swec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  swec_in_if.sink    item,
  swec_out_if.source result
);

  state_t      state;
  state_t      state_next;
  cmd_t        cmd_q;
  logic [31:0] minute_q;
  logic [31:0] delta_q;
  logic [31:0] last_seen;
  idx_t        active_bucket;
  logic [47:0] total_events;
  idx_t        idx_q;
  logic        moved_q;
  logic [CNT_W-1:0] sum_cnt;
  logic [34:0] sum_acc;

  logic        out_valid;
  logic [34:0] out_sum;
  logic [47:0] out_life;
  logic        out_adv;

  store_req_t  store_req;
  bucket_t     rd_data;
  mod_req_t    mod_req;
  mod_rsp_t    mod_rsp;

  logic        rec_or_adv;
  logic        moving;
  logic [31:0] diff;
  logic        use_mod;
  logic [IDX_W:0] step_sum;
  idx_t        step_idx;
  logic [48:0] total_add;
  logic [47:0] total_sat;
  logic [32:0] cnt_add;
  logic [31:0] cnt_sat;
  logic [31:0] age;
  logic        in_window;
  logic [35:0] acc_add;
  logic [34:0] acc_sat;
  logic        out_load;

  swec_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  swec_bucket_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (store_req),
    .rd_data (rd_data)
  );

  always_comb begin
    rec_or_adv = (cmd_q == CMD_RECORD) || (cmd_q == CMD_ADVANCE);
    moving     = rec_or_adv && (minute_q != last_seen);
    diff       = minute_q - last_seen;
    use_mod    = (last_seen == 32'd0) || (minute_q < last_seen) ||
                 (diff >= 32'(NUM_BUCKETS));
    step_sum   = {1'b0, active_bucket} + diff[IDX_W:0];
    if (step_sum >= (IDX_W+1)'(NUM_BUCKETS)) begin
      step_idx = IDX_W'(step_sum - (IDX_W+1)'(NUM_BUCKETS));
    end else begin
      step_idx = step_sum[IDX_W-1:0];
    end
    total_add = {1'b0, total_events} + {17'd0, delta_q};
    total_sat = total_add[48] ? '1 : total_add[47:0];
    cnt_add   = {1'b0, rd_data.count} + {1'b0, delta_q};
    cnt_sat   = cnt_add[32] ? '1 : cnt_add[31:0];
    age       = minute_q - rd_data.stamp;
    in_window = (rd_data.stamp != 32'd0) && (rd_data.stamp <= minute_q) &&
                (age < 32'(NUM_BUCKETS));
    acc_add   = {1'b0, sum_acc} + {4'd0, rd_data.count};
    acc_sat   = acc_add[35] ? '1 : acc_add[34:0];
    out_load  = (state == S_DONE) && (!out_valid || result.ready);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item.valid) begin
          state_next = S_MOVE;
        end
      end
      S_MOVE: begin
        if (!rec_or_adv) begin
          state_next = S_SUM;
        end else if (!moving) begin
          state_next = (cmd_q == CMD_RECORD) ? S_READ : S_SUM;
        end else if (use_mod) begin
          state_next = S_MOD;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_MOD: begin
        if (mod_rsp.done) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: state_next = S_SUM;
      S_READ:  state_next = S_ADD;
      S_ADD:   state_next = S_SUM;
      S_SUM: begin
        if (sum_cnt == CNT_W'(NUM_BUCKETS)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || result.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item.ready        = (state == S_IDLE);
    mod_req.start     = (state == S_MOVE) && moving && use_mod;
    mod_req.dividend  = minute_q;
    store_req.clr     = (state == S_MOVE) && (cmd_q == CMD_CLEAR);
    store_req.wr_en   = 1'b0;
    store_req.rd_en   = 1'b0;
    store_req.addr    = active_bucket;
    store_req.wr_data = '0;
    case (state)
      S_WRITE: begin
        store_req.wr_en         = 1'b1;
        store_req.addr          = idx_q;
        store_req.wr_data.count = (cmd_q == CMD_RECORD) ? delta_q : 32'd0;
        store_req.wr_data.stamp = minute_q;
      end
      S_READ: begin
        store_req.rd_en = 1'b1;
      end
      S_ADD: begin
        store_req.wr_en         = 1'b1;
        store_req.wr_data.count = cnt_sat;
        store_req.wr_data.stamp = rd_data.stamp;
      end
      S_SUM: begin
        store_req.rd_en = (sum_cnt < CNT_W'(NUM_BUCKETS));
        store_req.addr  = sum_cnt[IDX_W-1:0];
      end
      default: begin
        store_req.wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      last_seen     <= '0;
      active_bucket <= '0;
      total_events  <= '0;
      moved_q       <= 1'b0;
      sum_cnt       <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            cmd_q    <= cmd_t'(item.cmd);
            minute_q <= item.minute;
            delta_q  <= item.delta;
          end
        end
        S_MOVE: begin
          moved_q <= moving;
          idx_q   <= step_idx;
          sum_cnt <= '0;
          sum_acc <= '0;
          if (cmd_q == CMD_CLEAR) begin
            last_seen     <= '0;
            active_bucket <= '0;
            total_events  <= '0;
          end
        end
        S_MOD: begin
          if (mod_rsp.done) begin
            idx_q <= mod_rsp.rem;
          end
        end
        S_WRITE: begin
          last_seen     <= minute_q;
          active_bucket <= idx_q;
          if (cmd_q == CMD_RECORD) begin
            total_events <= total_sat;
          end
        end
        S_ADD: begin
          total_events <= total_sat;
        end
        S_SUM: begin
          if (sum_cnt < CNT_W'(NUM_BUCKETS)) begin
            sum_cnt <= sum_cnt + 1'b1;
          end
          if ((sum_cnt != '0) && in_window) begin
            sum_acc <= acc_sat;
          end
        end
        default: begin
          sum_cnt <= sum_cnt;
        end
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sum  <= sum_acc;
      out_life <= total_events;
      out_adv  <= moved_q;
    end
  end

  assign result.valid           = out_valid;
  assign result.recent_total    = out_sum;
  assign result.lifetime_count  = out_life;
  assign result.window_advanced = out_adv;

  a_active_range: assert property (@(posedge clk) disable iff (rst)
    active_bucket <= IDX_W'(NUM_BUCKETS - 1))
    else $error("active bucket out of range");

  a_mod_done_state: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |-> (state == S_MOD))
    else $error("modulo result outside its wait state");

  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> (state == S_MOVE))
    else $error("accepted beat did not start the sequence");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    sum_cnt <= CNT_W'(NUM_BUCKETS))
    else $error("bucket sweep overran");

endmodule

`default_nettype wire
